// ===== design/hmfp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP message framing parser package
// Shared types, character constants and small helper functions.
// ----------------------------------------------------------------------------
package hmfp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BODY     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;
  localparam logic [1:0] KIND_MORE     = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [39:0]  PFX_STR = "HTTP/";
  localparam logic [111:0] CL_STR  = "content-length";
  localparam logic [135:0] TE_STR  = "transfer-encoding";
  localparam logic [55:0]  CK_STR  = "chunked";

  localparam logic [4:0] CL_LEN   = 5'd14;
  localparam logic [4:0] TE_LEN   = 5'd17;
  localparam logic [4:0] NO_MATCH = 5'd31;

  // Token match codes for the Transfer-Encoding, Content-Length and chunk size scans
  localparam logic [3:0] TOK_CK_DONE = 4'd7;
  localparam logic [3:0] TOK_CK_WS   = 4'd8;
  localparam logic [3:0] TOK_BAD     = 4'd15;
  localparam logic [3:0] TOK_DIGITS  = 4'd1;
  localparam logic [3:0] TOK_TRAIL   = 4'd2;

  // Largest accumulator values that still take one more decimal digit
  localparam logic [63:0] LEN_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DEC_LIM_LO = LEN_MAX / 64'd10;
  localparam logic [63:0] DEC_LIM_HI = (LEN_MAX - 64'd9) / 64'd10;

  typedef enum logic [14:0] {
    PH_PREFIX  = 15'h0001,
    PH_START   = 15'h0002,
    PH_HNAME   = 15'h0004,
    PH_HCL     = 15'h0008,
    PH_HTE     = 15'h0010,
    PH_HOTHER  = 15'h0020,
    PH_BODY    = 15'h0040,
    PH_CSIZE   = 15'h0080,
    PH_CEXT    = 15'h0100,
    PH_CDATA   = 15'h0200,
    PH_CCR     = 15'h0400,
    PH_CLF     = 15'h0800,
    PH_TRAILER = 15'h1000,
    PH_DONE    = 15'h2000,
    PH_ERROR   = 15'h4000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  prefix_match;
    logic        request_flag;
    logic [3:0]  start_line_count;
    logic [9:0]  status_value;
    logic [1:0]  crlf_tracker;
    logic [4:0]  length_name_match;
    logic [4:0]  encoding_name_match;
    logic [3:0]  token_match;
    logic [63:0] number_accum;
    logic        length_seen;
    logic [63:0] length_value;
    logic        chunked_seen;
    logic        error_latch;
    logic [63:0] bytes_remaining;
    logic [63:0] delivered_count;
  } st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic        request_msg;
    logic [9:0]  status_num;
    logic        has_length;
    logic [62:0] length_decl;
    logic        chunked;
    logic [63:0] body_count;
    logic        last_of_run;
  } res_t;

  function automatic st_t st_reset();
    st_t s;
    s = '0;
    s.phase = PH_PREFIX;
    return s;
  endfunction

  function automatic logic [7:0] to_low(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [7:0] pfx_char(logic [3:0] i);
    logic [39:0] t;
    t = PFX_STR << {i, 3'b000};
    return t[39:32];
  endfunction

  function automatic logic [4:0] cl_step(logic [4:0] m, logic [7:0] b);
    logic [111:0] t;
    t = CL_STR << {m, 3'b000};
    return (m < CL_LEN && to_low(b) == t[111:104]) ? m + 5'd1 : NO_MATCH;
  endfunction

  function automatic logic [4:0] te_step(logic [4:0] m, logic [7:0] b);
    logic [135:0] t;
    t = TE_STR << {m, 3'b000};
    return (m < TE_LEN && to_low(b) == t[135:128]) ? m + 5'd1 : NO_MATCH;
  endfunction

  function automatic logic [7:0] ck_char(logic [3:0] i);
    logic [55:0] t;
    t = CK_STR << {i, 3'b000};
    return t[55:48];
  endfunction

  // Build one result from the state at the moment it is raised
  function automatic res_t mk_res(st_t s, logic [1:0] kind, logic [7:0] b);
    res_t r;
    logic ok;
    ok = kind != KIND_ERROR &&
         (s.phase == PH_BODY || s.phase == PH_CSIZE || s.phase == PH_CEXT ||
          s.phase == PH_CDATA || s.phase == PH_CCR || s.phase == PH_CLF ||
          s.phase == PH_TRAILER || s.phase == PH_DONE);
    r = '0;
    r.kind        = kind;
    r.body_byte   = (kind == KIND_BODY) ? b : 8'd0;
    r.request_msg = ok & s.request_flag;
    r.status_num  = ok ? s.status_value : 10'd0;
    r.has_length  = ok & s.length_seen;
    r.length_decl = (ok && s.length_seen) ? s.length_value[62:0] : 63'd0;
    r.chunked     = ok & s.chunked_seen;
    r.body_count  = ok ? s.delivered_count : 64'd0;
    return r;
  endfunction

endpackage

// ===== design/hmfp_in_if.sv =====
// ----------------------------------------------------------------------------
// HTTP parser input channel
// Valid/ready channel carrying one raw message byte and its flags.
// ----------------------------------------------------------------------------
interface hmfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;
  logic       end_of_data;

  modport source (output valid, data_byte, first_of_message, end_of_data,
                  input ready);
  modport sink   (input valid, data_byte, first_of_message, end_of_data,
                  output ready);
endinterface

// ===== design/hmfp_out_if.sv =====
// ----------------------------------------------------------------------------
// HTTP parser result channel
// Valid/ready channel carrying one parse result.
// ----------------------------------------------------------------------------
interface hmfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  body_byte;
  logic        request_msg;
  logic [9:0]  status_num;
  logic        has_length;
  logic [62:0] length_decl;
  logic        chunked;
  logic [63:0] body_count;
  logic        last_of_run;

  modport source (output valid, kind, body_byte, request_msg, status_num,
                  has_length, length_decl, chunked, body_count, last_of_run,
                  input ready);
  modport sink   (input valid, kind, body_byte, request_msg, status_num,
                  has_length, length_decl, chunked, body_count, last_of_run,
                  output ready);
endinterface

// ===== design/hmfp_step.sv =====
// ----------------------------------------------------------------------------
// HTTP parser step logic
// Next parse state and up to two results for one input byte.
// ----------------------------------------------------------------------------
module hmfp_step (
  input  hmfp_pkg::st_t  st,
  input  logic [7:0]     data_byte,
  input  logic           first_of_message,
  input  logic           end_of_data,
  output hmfp_pkg::st_t  st_next,
  output hmfp_pkg::res_t res0,
  output hmfp_pkg::res_t res1,
  output logic [1:0]     res_count
);

  // Start line check, one byte
  function automatic hmfp_pkg::st_t start_byte(hmfp_pkg::st_t s0, logic [7:0] b);
    hmfp_pkg::st_t s;
    logic [3:0] c;
    s = s0;
    c = s.start_line_count;
    if (s.request_flag) begin
      if (c == 4'd0 || c == 4'd2) begin
        if (b == hmfp_pkg::CH_SP) s.error_latch = 1'b1;
        else s.start_line_count = c + 4'd1;
      end else if (c == 4'd1 || c == 4'd3) begin
        if (b == hmfp_pkg::CH_SP) s.start_line_count = c + 4'd1;
      end else if (c >= 4'd4 && c < 4'd9) begin
        if (b == hmfp_pkg::pfx_char(c - 4'd4)) s.start_line_count = c + 4'd1;
        else s.error_latch = 1'b1;
      end
    end else begin
      if (c == 4'd0) begin
        if (b == hmfp_pkg::CH_SP) s.start_line_count = 4'd1;
      end else if (c <= 4'd3) begin
        if (hmfp_pkg::is_dig(b)) begin
          s.status_value = 10'((s.status_value << 3) + (s.status_value << 1)
                               + {2'b00, b - 8'h30});
          s.start_line_count = c + 4'd1;
        end else s.error_latch = 1'b1;
      end else if (c == 4'd4) begin
        if (b == hmfp_pkg::CH_SP) s.start_line_count = 4'd5;
        else s.error_latch = 1'b1;
      end
    end
    return s;
  endfunction

  // Line content byte, by phase
  function automatic hmfp_pkg::st_t content(hmfp_pkg::st_t s0, logic [7:0] b);
    hmfp_pkg::st_t s;
    logic [63:0] d;
    logic [7:0]  lb;
    logic        bad;
    s   = s0;
    lb  = hmfp_pkg::to_low(b);
    d   = '0;
    bad = 1'b0;
    case (s.phase)
      hmfp_pkg::PH_START: s = start_byte(s, b);
      hmfp_pkg::PH_HNAME: begin
        if (b == hmfp_pkg::CH_COLON) begin
          if (s.length_name_match == 5'd0 && s.encoding_name_match == 5'd0)
            s.error_latch = 1'b1;
          s.phase = (s.length_name_match == hmfp_pkg::CL_LEN) ? hmfp_pkg::PH_HCL :
                    (s.encoding_name_match == hmfp_pkg::TE_LEN) ? hmfp_pkg::PH_HTE :
                    hmfp_pkg::PH_HOTHER;
          s.token_match  = 4'd0;
          s.number_accum = 64'd0;
        end else begin
          s.length_name_match   = hmfp_pkg::cl_step(s.length_name_match, b);
          s.encoding_name_match = hmfp_pkg::te_step(s.encoding_name_match, b);
        end
      end
      hmfp_pkg::PH_HCL: begin
        if (hmfp_pkg::is_ws(b)) begin
          if (s.token_match != 4'd0) s.token_match = hmfp_pkg::TOK_TRAIL;
        end else if (hmfp_pkg::is_dig(b) && s.token_match != hmfp_pkg::TOK_TRAIL) begin
          d = {56'd0, b - 8'h30};
          if (s.number_accum > ((d > 64'd7) ? hmfp_pkg::DEC_LIM_HI : hmfp_pkg::DEC_LIM_LO))
            s.error_latch = 1'b1;
          else s.number_accum = (s.number_accum << 3) + (s.number_accum << 1) + d;
          s.token_match = hmfp_pkg::TOK_DIGITS;
        end else s.error_latch = 1'b1;
      end
      hmfp_pkg::PH_HTE: begin
        if (b == hmfp_pkg::CH_COMMA) begin
          if (s.token_match == hmfp_pkg::TOK_CK_DONE || s.token_match == hmfp_pkg::TOK_CK_WS)
            s.chunked_seen = 1'b1;
          s.token_match = 4'd0;
        end else if (hmfp_pkg::is_ws(b)) begin
          if (s.token_match == hmfp_pkg::TOK_CK_DONE || s.token_match == hmfp_pkg::TOK_CK_WS)
            s.token_match = hmfp_pkg::TOK_CK_WS;
          else if (s.token_match != 4'd0) s.token_match = hmfp_pkg::TOK_BAD;
        end else if (s.token_match < hmfp_pkg::TOK_CK_DONE &&
                     lb == hmfp_pkg::ck_char(s.token_match))
          s.token_match = s.token_match + 4'd1;
        else s.token_match = hmfp_pkg::TOK_BAD;
      end
      hmfp_pkg::PH_CSIZE: begin
        if (b == hmfp_pkg::CH_SEMI) s.phase = hmfp_pkg::PH_CEXT;
        else if (!hmfp_pkg::is_ws(b)) begin
          if (hmfp_pkg::is_dig(b)) d = {56'd0, b - 8'h30};
          else if (lb >= 8'h61 && lb <= 8'h66) d = {56'd0, lb - 8'h57};
          else bad = 1'b1;
          if (bad) s.error_latch = 1'b1;
          else begin
            if (s.number_accum[63:60] != 4'd0) s.error_latch = 1'b1;
            else s.number_accum = (s.number_accum << 4) | d;
            s.token_match = hmfp_pkg::TOK_DIGITS;
          end
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  hmfp_pkg::st_t  s;
  hmfp_pkg::res_t r0;
  hmfp_pkg::res_t r1;
  hmfp_pkg::res_t rx;
  logic [1:0]     n;
  logic           emit;
  logic [1:0]     ekind;
  logic           do_line;
  logic           blank;
  logic           got_lf;
  logic           emit2;
  logic [1:0]     ekind2;

  always_comb begin
    s       = first_of_message ? hmfp_pkg::st_reset() : st;
    r0      = '0;
    r1      = '0;
    rx      = '0;
    n       = 2'd0;
    emit    = 1'b0;
    ekind   = hmfp_pkg::KIND_ERROR;
    emit2   = 1'b0;
    ekind2  = hmfp_pkg::KIND_COMPLETE;
    do_line = 1'b0;
    blank   = 1'b0;
    got_lf  = 1'b0;

    // Phase dispatch
    case (s.phase)
      hmfp_pkg::PH_PREFIX: begin
        if (s.prefix_match < 3'd5 &&
            data_byte == hmfp_pkg::pfx_char({1'b0, s.prefix_match})) begin
          s.prefix_match = s.prefix_match + 3'd1;
          if (s.prefix_match == 3'd5) begin
            s.request_flag     = 1'b0;
            s.phase            = hmfp_pkg::PH_START;
            s.start_line_count = 4'd0;
          end
        end else begin
          s.request_flag     = 1'b1;
          s.phase            = hmfp_pkg::PH_START;
          s.start_line_count = (s.prefix_match != 3'd0) ? 4'd1 : 4'd0;
          do_line            = 1'b1;
        end
      end
      hmfp_pkg::PH_BODY, hmfp_pkg::PH_CDATA: begin
        if (s.bytes_remaining != 64'd0) s.bytes_remaining = s.bytes_remaining - 64'd1;
        s.delivered_count = s.delivered_count + 64'd1;
        rx = hmfp_pkg::mk_res(s, hmfp_pkg::KIND_BODY, data_byte);
        r0 = rx;
        n  = 2'd1;
        if (s.bytes_remaining == 64'd0) begin
          if (s.phase == hmfp_pkg::PH_BODY) begin
            s.phase = hmfp_pkg::PH_DONE;
            r1 = hmfp_pkg::mk_res(s, hmfp_pkg::KIND_COMPLETE, 8'd0);
            n  = 2'd2;
          end else s.phase = hmfp_pkg::PH_CCR;
        end
      end
      hmfp_pkg::PH_CCR: begin
        s.error_latch = data_byte != hmfp_pkg::CH_CR;
        s.phase       = hmfp_pkg::PH_CLF;
      end
      hmfp_pkg::PH_CLF: begin
        if (s.error_latch || data_byte != hmfp_pkg::CH_LF) begin
          s.phase = hmfp_pkg::PH_ERROR;
          emit    = 1'b1;
        end else begin
          s.phase        = hmfp_pkg::PH_CSIZE;
          s.crlf_tracker = 2'd0;
          s.number_accum = 64'd0;
          s.token_match  = 4'd0;
        end
      end
      hmfp_pkg::PH_TRAILER: begin
        if (data_byte == hmfp_pkg::CH_CR)
          s.crlf_tracker = (s.crlf_tracker == 2'd2) ? 2'd3 : 2'd1;
        else if (data_byte == hmfp_pkg::CH_LF && s.crlf_tracker == 2'd3) begin
          s.phase = hmfp_pkg::PH_DONE;
          emit    = 1'b1;
          ekind   = hmfp_pkg::KIND_COMPLETE;
        end else if (data_byte == hmfp_pkg::CH_LF && s.crlf_tracker == 2'd1)
          s.crlf_tracker = 2'd2;
        else s.crlf_tracker = 2'd0;
      end
      hmfp_pkg::PH_DONE, hmfp_pkg::PH_ERROR: ;
      default: do_line = 1'b1;
    endcase

    // Line framing: CR/LF tracking, line end and blank line
    if (do_line) begin
      if ((s.crlf_tracker == 2'd1 || s.crlf_tracker == 2'd3) &&
          data_byte == hmfp_pkg::CH_LF) begin
        got_lf = 1'b1;
        blank  = s.crlf_tracker == 2'd3;
        s.crlf_tracker = 2'd0;
      end else begin
        if (s.crlf_tracker == 2'd1 || s.crlf_tracker == 2'd3) begin
          s.crlf_tracker = 2'd0;
          s = content(s, hmfp_pkg::CH_CR);
        end
        if (data_byte == hmfp_pkg::CH_CR)
          s.crlf_tracker = (s.crlf_tracker == 2'd2) ? 2'd3 : 2'd1;
        else begin
          s.crlf_tracker = 2'd0;
          s = content(s, data_byte);
        end
      end
    end

    if (got_lf && blank) begin
      if (s.error_latch || s.start_line_count == 4'd0 ||
          (s.chunked_seen && s.length_seen)) begin
        s.phase = hmfp_pkg::PH_ERROR;
        emit    = 1'b1;
      end else if (s.length_seen && s.length_value != 64'd0) begin
        s.bytes_remaining = s.length_value;
        s.phase = hmfp_pkg::PH_BODY;
      end else if (!s.length_seen && s.chunked_seen) begin
        s.phase        = hmfp_pkg::PH_CSIZE;
        s.crlf_tracker = 2'd0;
        s.number_accum = 64'd0;
        s.token_match  = 4'd0;
      end else begin
        s.phase = hmfp_pkg::PH_DONE;
        emit    = 1'b1;
        ekind   = hmfp_pkg::KIND_COMPLETE;
      end
    end else if (got_lf) begin
      if (s.phase == hmfp_pkg::PH_CSIZE || s.phase == hmfp_pkg::PH_CEXT) begin
        if (s.error_latch || s.token_match == 4'd0) begin
          s.phase = hmfp_pkg::PH_ERROR;
          emit    = 1'b1;
        end else if (s.number_accum == 64'd0) begin
          s.phase        = hmfp_pkg::PH_TRAILER;
          s.crlf_tracker = 2'd2;
        end else begin
          s.bytes_remaining = s.number_accum;
          s.phase = hmfp_pkg::PH_CDATA;
        end
      end else begin
        if (s.phase == hmfp_pkg::PH_START) begin
          if (s.request_flag ? s.start_line_count != 4'd9 : s.start_line_count < 4'd4)
            s.error_latch = 1'b1;
          s.start_line_count = 4'd0;
        end else begin
          if (s.phase == hmfp_pkg::PH_HNAME) s.error_latch = 1'b1;
          else if (s.phase == hmfp_pkg::PH_HCL) begin
            if (s.token_match == 4'd0 ||
                (s.length_seen && s.length_value != s.number_accum))
              s.error_latch = 1'b1;
            else begin
              s.length_value = s.number_accum;
              s.length_seen  = 1'b1;
            end
          end else if (s.phase == hmfp_pkg::PH_HTE &&
                       (s.token_match == hmfp_pkg::TOK_CK_DONE ||
                        s.token_match == hmfp_pkg::TOK_CK_WS))
            s.chunked_seen = 1'b1;
          s.start_line_count = 4'd1;
        end
        s.phase               = hmfp_pkg::PH_HNAME;
        s.length_name_match   = 5'd0;
        s.encoding_name_match = 5'd0;
        s.crlf_tracker        = 2'd2;
      end
    end

    // Verdict raised by this byte
    if (emit) begin
      rx = hmfp_pkg::mk_res(s, ekind, 8'd0);
      if (n == 2'd0) begin
        r0 = rx;
        n  = 2'd1;
      end else if (n == 2'd1) begin
        r1 = rx;
        n  = 2'd2;
      end
    end

    // Need more data
    if (end_of_data && s.phase != hmfp_pkg::PH_DONE && s.phase != hmfp_pkg::PH_ERROR) begin
      emit2  = 1'b1;
      ekind2 = hmfp_pkg::KIND_MORE;
    end
    if (emit2) begin
      rx = hmfp_pkg::mk_res(s, ekind2, 8'd0);
      if (n == 2'd0) begin
        r0 = rx;
        n  = 2'd1;
      end else if (n == 2'd1) begin
        r1 = rx;
        n  = 2'd2;
      end
    end

    // Mark the final result of this byte
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign st_next   = s;
  assign res0      = r0;
  assign res1      = r1;
  assign res_count = n;

endmodule

// ===== design/hmfp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// HTTP parser result queue
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module hmfp_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  hmfp_pkg::res_t push0,
  input  hmfp_pkg::res_t push1,
  input  logic [1:0]     push_count,
  input  logic           pop,
  output hmfp_pkg::res_t head,
  output logic           not_empty,
  output logic           room2,
  output logic [2:0]     level
);

  hmfp_pkg::res_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;

  assign count_next = count + {1'b0, push_count} - {2'b00, pop};

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // Write the new results
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push1;
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != 3'd0;
  assign room2     = count <= 3'd2;
  assign level     = count;

endmodule

// ===== design/http_message_framing_parser.sv =====
// ----------------------------------------------------------------------------
// HTTP message framing parser
// Byte-wide HTTP/1.x framing check with Content-Length and chunked body
// delivery.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw message byte per transaction, with first_of_message
//   to clear parse state before the byte and end_of_data to ask for a
//   need-more verdict when the byte is the last one available.
//   out_ch carries results: body bytes, complete, error or need-more, with
//   the message metadata; last_of_run marks the final result of a byte.
//   Each byte is parsed by the combinational step logic against the state
//   register; its zero, one or two results are written into a four-entry
//   result queue, whose head drives out_ch. Throughput is one byte per
//   cycle while the queue has room for two results; in_ch.ready drops when
//   it holds three or more, so a stalled receiver halts input and nothing
//   is lost.
//   Reset clears the parse state and empties the queue; the block takes
//   bytes in the cycle after reset is released.
// ----------------------------------------------------------------------------
module http_message_framing_parser (
  input logic       clk,
  input logic       rst,
  hmfp_in_if.sink   in_ch,
  hmfp_out_if.source out_ch
);

  hmfp_pkg::st_t  st;
  hmfp_pkg::st_t  st_next;
  hmfp_pkg::res_t res0;
  hmfp_pkg::res_t res1;
  hmfp_pkg::res_t head;
  logic [1:0]     res_count;
  logic           in_acc;
  logic           room2;
  logic           not_empty;
  logic [2:0]     level;

  assign in_ch.ready = room2;
  assign in_acc      = in_ch.valid & room2;

  hmfp_step u_step (
    .st               (st),
    .data_byte        (in_ch.data_byte),
    .first_of_message (in_ch.first_of_message),
    .end_of_data      (in_ch.end_of_data),
    .st_next          (st_next),
    .res0             (res0),
    .res1             (res1),
    .res_count        (res_count)
  );

  // Hold parse state, advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hmfp_pkg::st_reset();
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  hmfp_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (in_acc ? res_count : 2'd0),
    .pop        (out_ch.valid & out_ch.ready),
    .head       (head),
    .not_empty  (not_empty),
    .room2      (room2),
    .level      (level)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid       = not_empty;
  assign out_ch.kind        = head.kind;
  assign out_ch.body_byte   = head.body_byte;
  assign out_ch.request_msg = head.request_msg;
  assign out_ch.status_num  = head.status_num;
  assign out_ch.has_length  = head.has_length;
  assign out_ch.length_decl = head.length_decl;
  assign out_ch.chunked     = head.chunked;
  assign out_ch.body_count  = head.body_count;
  assign out_ch.last_of_run = head.last_of_run;

`ifndef ASSERT_OFF
  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    in_acc && res_count != 2'd0 |=> out_ch.valid)
    else $error("accepted byte with results left no result visible");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= 3'd4)
    else $error("result queue overflow");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == hmfp_pkg::KIND_ERROR |->
      out_ch.body_count == 64'd0 && !out_ch.request_msg && !out_ch.has_length)
    else $error("error result carries metadata");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_ch.valid && !(out_ch.valid && out_ch.ready) |=> $stable(level))
    else $error("queue level moved with no transaction");
`endif

endmodule
